>>> rtl/core/ecc_pkg.sv
package ecc_pkg;

  localparam logic [11:0] EPOCH_YEAR     = 12'd1970;
  localparam logic [6:0]  EPOCH_MOD100   = 7'd70;
  localparam logic [8:0]  EPOCH_MOD400   = 9'd370;
  localparam logic [6:0]  LAST_MOD100    = 7'd99;
  localparam logic [8:0]  LAST_MOD400    = 9'd399;
  localparam logic [16:0] SEC_PER_DAY    = 17'd86400;
  localparam logic [16:0] SEC_PER_HOUR   = 17'd3600;
  localparam logic [16:0] SEC_PER_MIN    = 17'd60;
  localparam logic [20:0] DAYS_PER_ERA   = 21'd146097;
  localparam logic [12:0] YEARS_PER_ERA  = 13'd400;
  localparam logic [17:0] DAYS_PER_YEAR  = 18'd365;
  localparam logic [31:0] DAY_BIAS       = 32'd865566;
  localparam logic [4:0]  ZONE_RESET     = 5'd8;
  localparam logic [1:0]  DIV_STEPS      = 2'd3;
  localparam logic [25:0] RECIP_DAY      = 26'd50903317;
  localparam logic [13:0] RECIP_HOUR     = 14'd9321;
  localparam logic [10:0] RECIP_MIN      = 11'd1093;
  localparam logic [16:0] RECIP_WEEK     = 17'd74899;
  localparam logic [2:0]  WEEKDAY_EPOCH  = 3'd5;
  localparam logic [3:0]  DAYS_PER_WEEK  = 4'd7;

  typedef enum logic [1:0] {
    DIV_DAY,
    DIV_HOUR,
    DIV_MIN
  } ecc_dsel_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_ERA,
    OP_MUL,
    OP_DAYS,
    OP_SCALE,
    OP_SUM,
    OP_DIV_START,
    OP_DIV_NEXT,
    OP_YEAR,
    OP_MONTH,
    OP_FINISH
  } ecc_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_ERA,
    ST_MUL,
    ST_DAYS,
    ST_SCALE,
    ST_SUM,
    ST_DIV_DAY,
    ST_DIV_HOUR,
    ST_DIV_MIN,
    ST_YEAR,
    ST_MONTH,
    ST_DONE
  } ecc_state_t;

  typedef struct packed {
    ecc_op_t   op;
    ecc_dsel_t dsel;
  } ecc_cmd_t;

  typedef struct packed {
    logic act;
    logic era_done;
    logic div_done;
    logic year_done;
    logic month_done;
  } ecc_sts_t;

  function automatic logic [16:0] divisor_of(input ecc_dsel_t dsel);
    logic [16:0] d;
    case (dsel)
      DIV_DAY:  d = SEC_PER_DAY;
      DIV_HOUR: d = SEC_PER_HOUR;
      DIV_MIN:  d = SEC_PER_MIN;
      default:  d = SEC_PER_MIN;
    endcase
    return d;
  endfunction

  function automatic logic [8:0] doy_of_month(input logic [3:0] m);
    logic [8:0] d;
    case (m)
      4'd1:    d = 9'd306;
      4'd2:    d = 9'd337;
      4'd3:    d = 9'd0;
      4'd4:    d = 9'd31;
      4'd5:    d = 9'd61;
      4'd6:    d = 9'd92;
      4'd7:    d = 9'd122;
      4'd8:    d = 9'd153;
      4'd9:    d = 9'd184;
      4'd10:   d = 9'd214;
      4'd11:   d = 9'd245;
      4'd12:   d = 9'd275;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] n;
    case (m) inside
      4'd2:                      n = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   n = 5'd30;
      default:                   n = 5'd31;
    endcase
    return n;
  endfunction

endpackage

>>> rtl/core/epoch_calendar_converter.sv
// Date to stamp: the time from input beat to result valid is set by the era count loop.
// Stamp to date: the time is set by the one-year-per-cycle calendar walk from 1970
// and the month walk; each of the three constant divisions is done by reciprocal
// multiply. One item in flight; the next input beat is taken once the result register
// is loaded, while that result may still wait.
// Reset: controller idle, no result pending, zone offset 8 hours.
module epoch_calendar_converter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_action,
  input  logic [11:0] in_year,
  input  logic [3:0]  in_month,
  input  logic [4:0]  in_day,
  input  logic [4:0]  in_hour,
  input  logic [5:0]  in_minute,
  input  logic [5:0]  in_second,
  input  logic [31:0] in_stamp,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_stamp,
  output logic [11:0] out_year,
  output logic [3:0]  out_month,
  output logic [4:0]  out_day,
  output logic [4:0]  out_hour,
  output logic [5:0]  out_minute,
  output logic [5:0]  out_second,
  output logic [2:0]  out_weekday,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_zone_hours
);
  import ecc_pkg::*;

  ecc_cmd_t cmd;
  ecc_sts_t sts;

  ecc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  ecc_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_we         (cfg_we),
    .cfg_zone_hours (cfg_zone_hours),
    .in_action      (in_action),
    .in_year        (in_year),
    .in_month       (in_month),
    .in_day         (in_day),
    .in_hour        (in_hour),
    .in_minute      (in_minute),
    .in_second      (in_second),
    .in_stamp       (in_stamp),
    .out_stamp      (out_stamp),
    .out_year       (out_year),
    .out_month      (out_month),
    .out_day        (out_day),
    .out_hour       (out_hour),
    .out_minute     (out_minute),
    .out_second     (out_second),
    .out_weekday    (out_weekday)
  );

endmodule

>>> rtl/core/ecc_div.sv
module ecc_div (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  ecc_pkg::ecc_dsel_t dsel,
  input  logic [31:0]       dividend,
  output logic [31:0]       quo,
  output logic [16:0]       rem,
  output logic [2:0]        quo_mod7,
  output logic              done
);
  import ecc_pkg::*;

  logic [31:0] num_r, num_nxt;
  logic [15:0] quo_r, quo_nxt;
  logic [16:0] rem_r, rem_nxt;
  logic [12:0] q7_r, q7_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [2:0]  mod7_r, mod7_nxt;
  ecc_dsel_t   dsel_r, dsel_nxt;

  logic [50:0] prod_day;
  logic [26:0] prod_hour;
  logic [20:0] prod_min;
  logic [31:0] prod_week;
  logic [31:0] back;
  logic [15:0] wk_diff;

  always_comb begin
    prod_day  = {26'b0, num_r[31:7]} * {25'b0, RECIP_DAY};
    prod_hour = {14'b0, num_r[16:4]} * {13'b0, RECIP_HOUR};
    prod_min  = {11'b0, num_r[11:2]} * {10'b0, RECIP_MIN};
    prod_week = {16'b0, quo_r} * {15'b0, RECIP_WEEK};
    back      = {16'b0, quo_r} * {15'b0, divisor_of(dsel_r)};
    wk_diff   = quo_r - ({q7_r, 3'b000} - {3'b000, q7_r});
    num_nxt   = num_r;
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    q7_nxt    = q7_r;
    cnt_nxt   = cnt_r;
    mod7_nxt  = mod7_r;
    dsel_nxt  = dsel_r;
    if (start) begin
      num_nxt  = dividend;
      dsel_nxt = dsel;
      cnt_nxt  = DIV_STEPS;
    end else begin
      case (cnt_r)
        2'd3: begin
          case (dsel_r)
            DIV_DAY:  quo_nxt = prod_day[50:35];
            DIV_HOUR: quo_nxt = {10'b0, prod_hour[26:21]};
            DIV_MIN:  quo_nxt = {9'b0, prod_min[20:14]};
            default:  quo_nxt = {9'b0, prod_min[20:14]};
          endcase
          cnt_nxt = cnt_r - 2'd1;
        end
        2'd2: begin
          rem_nxt = 17'(num_r - back);
          q7_nxt  = prod_week[31:19];
          cnt_nxt = cnt_r - 2'd1;
        end
        2'd1: begin
          mod7_nxt = wk_diff[2:0];
          cnt_nxt  = cnt_r - 2'd1;
        end
        default: begin
          cnt_nxt = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r  <= num_nxt;
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    q7_r   <= q7_nxt;
    mod7_r <= mod7_nxt;
    dsel_r <= dsel_nxt;
  end

  assign quo      = {16'b0, quo_r};
  assign rem      = rem_r;
  assign quo_mod7 = mod7_r;
  assign done     = (cnt_r == '0);

endmodule

>>> rtl/core/ecc_dp.sv
module ecc_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  ecc_pkg::ecc_cmd_t cmd,
  output ecc_pkg::ecc_sts_t sts,
  input  logic              cfg_we,
  input  logic [4:0]        cfg_zone_hours,
  input  logic              in_action,
  input  logic [11:0]       in_year,
  input  logic [3:0]        in_month,
  input  logic [4:0]        in_day,
  input  logic [4:0]        in_hour,
  input  logic [5:0]        in_minute,
  input  logic [5:0]        in_second,
  input  logic [31:0]       in_stamp,
  output logic [31:0]       out_stamp,
  output logic [11:0]       out_year,
  output logic [3:0]        out_month,
  output logic [4:0]        out_day,
  output logic [4:0]        out_hour,
  output logic [5:0]        out_minute,
  output logic [5:0]        out_second,
  output logic [2:0]        out_weekday
);
  import ecc_pkg::*;

  logic [4:0]  zone_r;
  logic        act_r, act_nxt;
  logic [3:0]  mon_r, mon_nxt;
  logic [4:0]  day_in_r, day_in_nxt;
  logic [4:0]  hour_in_r, hour_in_nxt;
  logic [5:0]  min_in_r, min_in_nxt;
  logic [5:0]  sec_in_r, sec_in_nxt;
  logic [12:0] yy_r, yy_nxt;
  logic [3:0]  era_r, era_nxt;
  logic [31:0] t_r, t_nxt;
  logic [17:0] mula_r, mula_nxt;
  logic [20:0] mulb_r, mulb_nxt;
  logic [9:0]  aux_r, aux_nxt;
  logic [31:0] days32_r, days32_nxt;
  logic [31:0] prod_r, prod_nxt;
  logic [31:0] hms_r, hms_nxt;
  logic [31:0] stamp_r, stamp_nxt;
  logic [15:0] days_r, days_nxt;
  logic [2:0]  wd_r, wd_nxt;
  logic [4:0]  hour_r, hour_nxt;
  logic [5:0]  min_r, min_nxt;
  logic [5:0]  sec_r, sec_nxt;
  logic [11:0] year_r, year_nxt;
  logic [6:0]  c100_r, c100_nxt;
  logic [8:0]  c400_r, c400_nxt;
  logic [3:0]  month_r, month_nxt;

  logic [31:0] o_stamp_r, o_stamp_nxt;
  logic [11:0] o_year_r, o_year_nxt;
  logic [3:0]  o_month_r, o_month_nxt;
  logic [4:0]  o_day_r, o_day_nxt;
  logic [4:0]  o_hour_r, o_hour_nxt;
  logic [5:0]  o_min_r, o_min_nxt;
  logic [5:0]  o_sec_r, o_sec_nxt;
  logic [2:0]  o_wd_r, o_wd_nxt;

  logic        div_start;
  ecc_dsel_t   div_dsel;
  logic [31:0] div_dividend;
  logic [31:0] div_quo;
  logic [16:0] div_rem;
  logic [2:0]  div_mod7;
  logic        div_done;

  logic [3:0]  mc;
  logic [8:0]  yoe;
  logic [1:0]  cent;
  logic        leap;
  logic [8:0]  ylen;
  logic [4:0]  mlen;
  logic [3:0]  wsum;

  ecc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dsel     (div_dsel),
    .dividend (div_dividend),
    .quo      (div_quo),
    .rem      (div_rem),
    .quo_mod7 (div_mod7),
    .done     (div_done)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zone_r <= ZONE_RESET;
    end else if (cfg_we) begin
      zone_r <= cfg_zone_hours;
    end
  end

  always_comb begin
    mc   = (in_month == 4'd0) ? 4'd1 : ((in_month > 4'd12) ? 4'd12 : in_month);
    yoe  = yy_r[8:0];
    cent = (yoe >= 9'd300) ? 2'd3 : (yoe >= 9'd200) ? 2'd2 : (yoe >= 9'd100) ? 2'd1 : 2'd0;
    leap = (year_r[1:0] == 2'b00) && ((c100_r != 7'd0) || (c400_r == 9'd0));
    ylen = leap ? 9'd366 : 9'd365;
    mlen = month_len(month_r, leap);
    wsum = {1'b0, div_mod7} + {1'b0, WEEKDAY_EPOCH};
  end

  always_comb begin
    act_nxt     = act_r;
    mon_nxt     = mon_r;
    day_in_nxt  = day_in_r;
    hour_in_nxt = hour_in_r;
    min_in_nxt  = min_in_r;
    sec_in_nxt  = sec_in_r;
    yy_nxt      = yy_r;
    era_nxt     = era_r;
    t_nxt       = t_r;
    mula_nxt    = mula_r;
    mulb_nxt    = mulb_r;
    aux_nxt     = aux_r;
    days32_nxt  = days32_r;
    prod_nxt    = prod_r;
    hms_nxt     = hms_r;
    stamp_nxt   = stamp_r;
    days_nxt    = days_r;
    wd_nxt      = wd_r;
    hour_nxt    = hour_r;
    min_nxt     = min_r;
    sec_nxt     = sec_r;
    year_nxt    = year_r;
    c100_nxt    = c100_r;
    c400_nxt    = c400_r;
    month_nxt   = month_r;
    o_stamp_nxt = o_stamp_r;
    o_year_nxt  = o_year_r;
    o_month_nxt = o_month_r;
    o_day_nxt   = o_day_r;
    o_hour_nxt  = o_hour_r;
    o_min_nxt   = o_min_r;
    o_sec_nxt   = o_sec_r;
    o_wd_nxt    = o_wd_r;
    div_start    = 1'b0;
    div_dsel     = DIV_DAY;
    div_dividend = t_r;

    case (cmd.op)
      OP_LOAD: begin
        act_nxt     = in_action;
        mon_nxt     = mc;
        day_in_nxt  = in_day;
        hour_in_nxt = in_hour;
        min_in_nxt  = in_minute;
        sec_in_nxt  = in_second;
        yy_nxt      = {1'b0, in_year} + YEARS_PER_ERA - {12'b0, (mc <= 4'd2)};
        era_nxt     = '0;
        t_nxt       = in_stamp + 32'(32'(zone_r) * 32'(SEC_PER_HOUR));
        year_nxt    = EPOCH_YEAR;
        c100_nxt    = EPOCH_MOD100;
        c400_nxt    = EPOCH_MOD400;
        month_nxt   = 4'd1;
      end
      OP_ERA: begin
        if (yy_r >= YEARS_PER_ERA) begin
          yy_nxt  = yy_r - YEARS_PER_ERA;
          era_nxt = era_r + 4'd1;
        end
      end
      OP_MUL: begin
        mula_nxt = 18'(18'(yoe) * DAYS_PER_YEAR);
        mulb_nxt = 21'(21'(era_r) * DAYS_PER_ERA);
        aux_nxt  = {3'b0, yoe[8:2]} - {8'b0, cent} + {1'b0, doy_of_month(mon_r)}
                   + {5'b0, day_in_r};
      end
      OP_DAYS: begin
        days32_nxt = 32'(mula_r) + 32'(mulb_r) + 32'(aux_r) - DAY_BIAS;
      end
      OP_SCALE: begin
        prod_nxt = 32'(days32_r * 32'(SEC_PER_DAY));
        hms_nxt  = 32'(32'(hour_in_r) * 32'(SEC_PER_HOUR))
                 + 32'(32'(min_in_r) * 32'(SEC_PER_MIN))
                 + 32'(sec_in_r)
                 - 32'(32'(zone_r) * 32'(SEC_PER_HOUR));
      end
      OP_SUM: begin
        stamp_nxt = prod_r + hms_r;
      end
      OP_DIV_START: begin
        div_start    = 1'b1;
        div_dsel     = DIV_DAY;
        div_dividend = t_r;
      end
      OP_DIV_NEXT: begin
        div_dividend = {15'b0, div_rem};
        case (cmd.dsel)
          DIV_DAY: begin
            days_nxt  = div_quo[15:0];
            wd_nxt    = (wsum >= DAYS_PER_WEEK) ? 3'(wsum - DAYS_PER_WEEK) : wsum[2:0];
            div_start = 1'b1;
            div_dsel  = DIV_HOUR;
          end
          DIV_HOUR: begin
            hour_nxt  = div_quo[4:0];
            div_start = 1'b1;
            div_dsel  = DIV_MIN;
          end
          DIV_MIN: begin
            min_nxt = div_quo[5:0];
            sec_nxt = div_rem[5:0];
          end
          default: begin
            div_start = 1'b0;
          end
        endcase
      end
      OP_YEAR: begin
        if (days_r >= {7'b0, ylen}) begin
          days_nxt = days_r - {7'b0, ylen};
          year_nxt = year_r + 12'd1;
          c100_nxt = (c100_r == LAST_MOD100) ? 7'd0 : c100_r + 7'd1;
          c400_nxt = (c400_r == LAST_MOD400) ? 9'd0 : c400_r + 9'd1;
        end
      end
      OP_MONTH: begin
        if (days_r >= {11'b0, mlen}) begin
          days_nxt  = days_r - {11'b0, mlen};
          month_nxt = month_r + 4'd1;
        end
      end
      OP_FINISH: begin
        if (act_r) begin
          o_stamp_nxt = '0;
          o_year_nxt  = year_r;
          o_month_nxt = month_r;
          o_day_nxt   = days_r[4:0] + 5'd1;
          o_hour_nxt  = hour_r;
          o_min_nxt   = min_r;
          o_sec_nxt   = sec_r;
          o_wd_nxt    = wd_r;
        end else begin
          o_stamp_nxt = stamp_r;
          o_year_nxt  = '0;
          o_month_nxt = '0;
          o_day_nxt   = '0;
          o_hour_nxt  = '0;
          o_min_nxt   = '0;
          o_sec_nxt   = '0;
          o_wd_nxt    = '0;
        end
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    act_r     <= act_nxt;
    mon_r     <= mon_nxt;
    day_in_r  <= day_in_nxt;
    hour_in_r <= hour_in_nxt;
    min_in_r  <= min_in_nxt;
    sec_in_r  <= sec_in_nxt;
    yy_r      <= yy_nxt;
    era_r     <= era_nxt;
    t_r       <= t_nxt;
    mula_r    <= mula_nxt;
    mulb_r    <= mulb_nxt;
    aux_r     <= aux_nxt;
    days32_r  <= days32_nxt;
    prod_r    <= prod_nxt;
    hms_r     <= hms_nxt;
    stamp_r   <= stamp_nxt;
    days_r    <= days_nxt;
    wd_r      <= wd_nxt;
    hour_r    <= hour_nxt;
    min_r     <= min_nxt;
    sec_r     <= sec_nxt;
    year_r    <= year_nxt;
    c100_r    <= c100_nxt;
    c400_r    <= c400_nxt;
    month_r   <= month_nxt;
    o_stamp_r <= o_stamp_nxt;
    o_year_r  <= o_year_nxt;
    o_month_r <= o_month_nxt;
    o_day_r   <= o_day_nxt;
    o_hour_r  <= o_hour_nxt;
    o_min_r   <= o_min_nxt;
    o_sec_r   <= o_sec_nxt;
    o_wd_r    <= o_wd_nxt;
  end

  always_comb begin
    sts.act        = act_r;
    sts.era_done   = (yy_r < YEARS_PER_ERA);
    sts.div_done   = div_done;
    sts.year_done  = (days_r < {7'b0, ylen});
    sts.month_done = (days_r < {11'b0, mlen});
  end

  assign out_stamp   = o_stamp_r;
  assign out_year    = o_year_r;
  assign out_month   = o_month_r;
  assign out_day     = o_day_r;
  assign out_hour    = o_hour_r;
  assign out_minute  = o_min_r;
  assign out_second  = o_sec_r;
  assign out_weekday = o_wd_r;

endmodule

>>> rtl/core/ecc_ctrl.sv
module ecc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output ecc_pkg::ecc_cmd_t cmd,
  input  ecc_pkg::ecc_sts_t sts
);
  import ecc_pkg::*;

  ecc_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;

  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:     if (in_valid) state_nxt = ST_DISPATCH;
      ST_DISPATCH: state_nxt = sts.act ? ST_DIV_DAY : ST_ERA;
      ST_ERA:      if (sts.era_done) state_nxt = ST_MUL;
      ST_MUL:      state_nxt = ST_DAYS;
      ST_DAYS:     state_nxt = ST_SCALE;
      ST_SCALE:    state_nxt = ST_SUM;
      ST_SUM:      state_nxt = ST_DONE;
      ST_DIV_DAY:  if (sts.div_done) state_nxt = ST_DIV_HOUR;
      ST_DIV_HOUR: if (sts.div_done) state_nxt = ST_DIV_MIN;
      ST_DIV_MIN:  if (sts.div_done) state_nxt = ST_YEAR;
      ST_YEAR:     if (sts.year_done) state_nxt = ST_MONTH;
      ST_MONTH:    if (sts.month_done) state_nxt = ST_DONE;
      ST_DONE:     if (slot_free) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.op   = OP_NONE;
    cmd.dsel = DIV_DAY;
    in_stall = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) cmd.op = OP_LOAD;
      end
      ST_DISPATCH: begin
        if (sts.act) cmd.op = OP_DIV_START;
      end
      ST_ERA:   cmd.op = OP_ERA;
      ST_MUL:   cmd.op = OP_MUL;
      ST_DAYS:  cmd.op = OP_DAYS;
      ST_SCALE: cmd.op = OP_SCALE;
      ST_SUM:   cmd.op = OP_SUM;
      ST_DIV_DAY: begin
        cmd.dsel = DIV_DAY;
        if (sts.div_done) cmd.op = OP_DIV_NEXT;
      end
      ST_DIV_HOUR: begin
        cmd.dsel = DIV_HOUR;
        if (sts.div_done) cmd.op = OP_DIV_NEXT;
      end
      ST_DIV_MIN: begin
        cmd.dsel = DIV_MIN;
        if (sts.div_done) cmd.op = OP_DIV_NEXT;
      end
      ST_YEAR:  cmd.op = OP_YEAR;
      ST_MONTH: cmd.op = OP_MONTH;
      ST_DONE: begin
        if (slot_free) cmd.op = OP_FINISH;
      end
      default: cmd.op = OP_NONE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.op == OP_FINISH) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule
